FILE: rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared sizes, codes and controller/datapath interface types for the
// min tracking stack.
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

	// stack geometry
	localparam int DEPTH  = 16;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	// capacity register and output count are fixed at five bits
	localparam int CAP_W  = 5;
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// operation codes
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP_WAIT,
		S_SCAN,
		S_EMIT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic latch;       // capture incoming beat
		logic do_push;     // store word, update minimum, bump count
		logic flag_full;   // mark push refused
		logic flag_empty;  // mark pop refused
		logic rd_top;      // read top entry
		logic take_pop;    // capture popped word, drop count
		logic scan_start;  // issue read of entry zero
		logic scan_step;   // fold one word into the running minimum
		logic emit;        // load output register
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic op_pop;      // latched operation is a pop
		logic full;        // no room for a push
		logic empty;       // nothing to pop
		logic hit_min;     // top entry is the minimum position
		logic multi;       // more than one entry held
		logic scan_done;   // last remaining entry is on the read data
		logic out_free;    // output register can take a beat
	} dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                           wr_data,
	input  wire logic                                       rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// Controller for the min tracking stack: sequences push, pop, minimum
// rescan and result hand-off one operation at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ctrl import mts_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.op_pop) begin
					if (sts.empty) begin
						cmd.flag_empty = 1'b1;
						state_nxt      = S_EMIT;
					end else begin
						cmd.rd_top = 1'b1;
						state_nxt  = S_POP_WAIT;
					end
				end else begin
					if (sts.full) begin
						cmd.flag_full = 1'b1;
					end else begin
						cmd.do_push = 1'b1;
					end
					state_nxt = S_EMIT;
				end
			end
			S_POP_WAIT: begin
				cmd.take_pop = 1'b1;
				if (sts.hit_min && sts.multi) begin
					cmd.scan_start = 1'b1;
					state_nxt      = S_SCAN;
				end else begin
					state_nxt = S_EMIT;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					state_nxt = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/mts_dp.sv
// ----------------------------------------------------------------------------
// mts_dp
// Datapath for the min tracking stack: word RAM, count and minimum
// tracking, capacity register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_dp import mts_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic        [CAP_W-1:0]  cfg_wdata,
	input  wire logic                     mode,
	input  wire logic signed [WORD_W-1:0] push_value,
	input  wire dp_cmd_t                  cmd,
	output dp_sts_t                       sts,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed      [WORD_W-1:0] popped_value,
	output logic signed      [WORD_W-1:0] minimum_value,
	output logic                          minimum_valid,
	output logic             [CAP_W-1:0]  entry_count,
	output logic             [1:0]        status
);

	// control state
	logic [CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] min_pos_q;
	logic [ADDR_W-1:0] data_pos_q;
	logic              out_valid_q;

	// payload state
	logic                     op_mode_q;
	logic signed [WORD_W-1:0] op_value_q;
	logic signed [WORD_W-1:0] min_val_q;
	logic signed [WORD_W-1:0] popped_q;
	status_t                  status_q;
	logic signed [WORD_W-1:0] out_popped_q;
	logic signed [WORD_W-1:0] out_min_q;
	logic                     out_min_valid_q;
	logic [CAP_W-1:0]         out_count_q;
	status_t                  out_status_q;

	// ram ports
	logic                     rd_en;
	logic [ADDR_W-1:0]        rd_addr;
	logic [WORD_W-1:0]        rd_data;
	logic signed [WORD_W-1:0] rd_word;
	logic [ADDR_W-1:0]        top_addr;
	logic [ADDR_W-1:0]        last_addr;

	assign top_addr  = count_q[ADDR_W-1:0];
	assign last_addr = ADDR_W'(count_q - CNT_W'(1));
	assign rd_word   = $signed(rd_data);

	mts_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (cmd.do_push),
		.wr_addr (top_addr),
		.wr_data (op_value_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// read address select: top entry, rescan start, rescan walk
	always_comb begin
		rd_en   = cmd.rd_top | cmd.scan_start | cmd.scan_step;
		rd_addr = data_pos_q + ADDR_W'(1);
		if (cmd.rd_top) begin
			rd_addr = last_addr;
		end else if (cmd.scan_start) begin
			rd_addr = '0;
		end
	end

	// status to controller
	always_comb begin
		sts.op_pop    = (op_mode_q == MODE_POP);
		sts.full      = (CMP_W'(count_q) >= CMP_W'(cap_q)) ||
		                (count_q >= CNT_W'(DEPTH));
		sts.empty     = (count_q == '0);
		sts.hit_min   = (last_addr == min_pos_q);
		sts.multi     = (count_q > CNT_W'(1));
		sts.scan_done = (data_pos_q == last_addr);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// count, minimum position and rescan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			min_pos_q  <= '0;
			data_pos_q <= '0;
		end else begin
			if (cmd.do_push) begin
				count_q <= count_q + CNT_W'(1);
				if (count_q == '0) begin
					min_pos_q <= '0;
				end else if (op_value_q < min_val_q) begin
					min_pos_q <= top_addr;
				end
			end
			if (cmd.take_pop) begin
				count_q <= count_q - CNT_W'(1);
				if (!sts.multi) begin
					min_pos_q <= '0;
				end
			end
			if (cmd.scan_start) begin
				data_pos_q <= '0;
			end
			if (cmd.scan_step) begin
				data_pos_q <= data_pos_q + ADDR_W'(1);
				if ((data_pos_q == '0) || (rd_word < min_val_q)) begin
					min_pos_q <= data_pos_q;
				end
			end
		end
	end

	// operation capture, minimum word and result staging
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_mode_q  <= mode;
			op_value_q <= push_value;
			popped_q   <= '0;
			status_q   <= ST_DONE;
		end
		if (cmd.flag_full) begin
			status_q <= ST_FULL;
		end
		if (cmd.flag_empty) begin
			status_q <= ST_EMPTY;
		end
		if (cmd.do_push && ((count_q == '0) || (op_value_q < min_val_q))) begin
			min_val_q <= op_value_q;
		end
		if (cmd.take_pop) begin
			popped_q <= rd_word;
		end
		if (cmd.scan_step && ((data_pos_q == '0) || (rd_word < min_val_q))) begin
			min_val_q <= rd_word;
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_popped_q    <= popped_q;
			out_min_q       <= (count_q != '0) ? min_val_q : '0;
			out_min_valid_q <= (count_q != '0);
			out_count_q     <= CAP_W'(count_q);
			out_status_q    <= status_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign popped_value  = out_popped_q;
	assign minimum_value = out_min_q;
	assign minimum_valid = out_min_valid_q;
	assign entry_count   = out_count_q;
	assign status        = out_status_q;

endmodule

`default_nettype wire

FILE: rtl/min_tracking_stack.sv
// An op is latched and executed, and a pop that is not refused reads its top
// entry; the result is then loaded into the output register. A pop that
// removes the minimum with entries left adds a rescan of up to DEPTH-1
// remaining entries, reading the word RAM one entry per cycle. One operation
// at a time: next beat taken the cycle after the output register is loaded.
// Reset: stack empty, capacity 16, no output beat; the word RAM is not cleared.
// ----------------------------------------------------------------------------
// min_tracking_stack
// Bounded stack of signed 32-bit words that reports its current minimum
// with every push or pop result.
// ----------------------------------------------------------------------------
`default_nettype none

module min_tracking_stack import mts_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic        [CAP_W-1:0]  cfg_wdata,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     mode,
	input  wire logic signed [WORD_W-1:0] push_value,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed      [WORD_W-1:0] popped_value,
	output logic signed      [WORD_W-1:0] minimum_value,
	output logic                          minimum_valid,
	output logic             [CAP_W-1:0]  entry_count,
	output logic             [1:0]        status
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	mts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mts_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.mode          (mode),
		.push_value    (push_value),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.popped_value  (popped_value),
		.minimum_value (minimum_value),
		.minimum_valid (minimum_valid),
		.entry_count   (entry_count),
		.status        (status)
	);

	// one operation in flight: accepted beat closes the input side
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while an operation is in flight");

	// controller issues at most one major command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.latch, cmd.do_push, cmd.rd_top, cmd.scan_step, cmd.emit}))
		else $error("conflicting datapath commands");

	// minimum flag tracks the count in every result
	a_min_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (minimum_valid == (entry_count != '0)))
		else $error("minimum valid does not match entry count");

	// refused pop leaves an empty stack and no word
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_EMPTY)) |->
		((entry_count == '0) && (popped_value == '0)))
		else $error("refused pop with data or entries");

	// count never passes the stack depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (CMP_W'(entry_count) <= CMP_W'(DEPTH)))
		else $error("entry count above depth");

endmodule

`default_nettype wire

FILE: tb/min_tracking_stack_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_tracking_stack_checker
// Watches the input, result and capacity ports of the min tracking stack,
// keeps a shadow copy of the stack to predict every result beat and
// compares each accepted result beat field by field, in order.
// ----------------------------------------------------------------------------

module min_tracking_stack_checker import mts_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic        [CAP_W-1:0]  cfg_wdata,
	input  wire logic                     in_valid,
	input  wire logic                     in_stall,
	input  wire logic                     mode,
	input  wire logic signed [WORD_W-1:0] push_value,
	input  wire logic                     out_valid,
	input  wire logic                     out_stall,
	input  wire logic signed [WORD_W-1:0] popped_value,
	input  wire logic signed [WORD_W-1:0] minimum_value,
	input  wire logic                     minimum_valid,
	input  wire logic        [CAP_W-1:0]  entry_count,
	input  wire logic        [1:0]        status,
	output int                            fail_count,
	output int                            pending
);

	// one predicted result beat
	typedef struct {
		logic signed [WORD_W-1:0] popped;
		logic signed [WORD_W-1:0] low_word;
		logic                     low_ok;
		logic        [CAP_W-1:0]  count;
		status_t                  st;
	} stack_result_t;

	// shadow stack and capacity
	logic signed [WORD_W-1:0] shadow_words [DEPTH];
	int unsigned              shadow_top;
	int unsigned              shadow_min_pos;
	logic        [CAP_W-1:0]  shadow_capacity;

	// results still owed by the block, oldest first
	stack_result_t            owed_results [$];

	initial fail_count = 0;

	task automatic note_mismatch(input string what, input longint got, input longint want);
		if (fail_count < 100) begin
			$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		end
		fail_count = fail_count + 1;
	endtask

	// apply one push or pop to the shadow stack and return its result
	function automatic stack_result_t apply_stack_op(input logic op,
			input logic signed [WORD_W-1:0] word);
		stack_result_t r;
		int unsigned   room;
		int unsigned   i;
		room     = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
		r.popped = '0;
		r.st     = ST_DONE;
		if (op == MODE_PUSH) begin
			if (shadow_top >= room) begin
				r.st = ST_FULL;
			end else begin
				shadow_words[shadow_top] = word;
				if (shadow_top == 0) begin
					shadow_min_pos = 0;
				end else if (word < shadow_words[shadow_min_pos]) begin
					shadow_min_pos = shadow_top;
				end
				shadow_top = shadow_top + 1;
			end
		end else if (shadow_top == 0) begin
			r.st = ST_EMPTY;
		end else begin
			shadow_top = shadow_top - 1;
			// minimum leaves: earliest smallest among the rest
			if (shadow_top == shadow_min_pos) begin
				shadow_min_pos = 0;
				for (i = 1; i < shadow_top; i++) begin
					if (shadow_words[i] < shadow_words[shadow_min_pos]) begin
						shadow_min_pos = i;
					end
				end
			end
			r.popped = shadow_words[shadow_top];
		end
		r.low_ok   = (shadow_top > 0);
		r.low_word = r.low_ok ? shadow_words[shadow_min_pos] : '0;
		r.count    = CAP_W'(shadow_top);
		return r;
	endfunction

	// compare result beats, track capacity writes, predict input beats
	always @(posedge clk or negedge arst_n) begin
		stack_result_t want;
		if (!arst_n) begin
			shadow_top      = 0;
			shadow_min_pos  = 0;
			shadow_capacity = CAP_RESET;
			owed_results.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					note_mismatch("result beat with nothing expected, popped_value",
						popped_value, 0);
				end else begin
					want = owed_results.pop_front();
					if (popped_value !== want.popped)
						note_mismatch("popped_value", popped_value, want.popped);
					if (minimum_value !== want.low_word)
						note_mismatch("minimum_value", minimum_value, want.low_word);
					if (minimum_valid !== want.low_ok)
						note_mismatch("minimum_valid", minimum_valid, want.low_ok);
					if (entry_count !== want.count)
						note_mismatch("entry_count", entry_count, want.count);
					if (status !== want.st)
						note_mismatch("status", status, want.st);
				end
			end
			if (cfg_we) begin
				shadow_capacity = cfg_wdata;
			end
			if (in_valid && !in_stall) begin
				owed_results.insert(owed_results.size(), apply_stack_op(mode, push_value));
			end
			pending <= owed_results.size();
		end
	end

endmodule

FILE: tb/min_tracking_stack_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_tracking_stack_tb
// Drives push and pop beats into the min tracking stack under a range of
// capacity settings, with random gaps and output stalls and one long
// output hold-off; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------

module min_tracking_stack_tb;
	import mts_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int HOLD_CYCLES     = 300;
	localparam int PHASES          = 7;
	localparam int ITEMS_PER_PHASE = 72;
	localparam int DRAIN_CYCLES    = DEPTH + 8;

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     cfg_we        = 1'b0;
	logic        [CAP_W-1:0]  cfg_wdata     = '0;
	logic                     in_valid      = 1'b0;
	logic                     in_stall;
	logic                     mode          = MODE_PUSH;
	logic signed [WORD_W-1:0] push_value    = '0;
	logic                     out_valid;
	logic                     out_stall     = 1'b0;
	logic signed [WORD_W-1:0] popped_value;
	logic signed [WORD_W-1:0] minimum_value;
	logic                     minimum_valid;
	logic        [CAP_W-1:0]  entry_count;
	logic        [1:0]        status;

	int                       fail_count;
	int                       pending;
	int                       cycle_count   = 0;
	logic                     idle_on       = 1'b1;
	int                       hold_asked    = 0;
	int                       hold_served   = 0;

	// capacity for each random phase: above depth, full depth, one, zero, ...
	logic [CAP_W-1:0] capacity_plan [PHASES] =
		'{5'd31, 5'd16, 5'd1, 5'd0, 5'd17, 5'd6, 5'd16};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	min_tracking_stack dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.push_value    (push_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.popped_value  (popped_value),
		.minimum_value (minimum_value),
		.minimum_valid (minimum_valid),
		.entry_count   (entry_count),
		.status        (status)
	);

	min_tracking_stack_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.push_value    (push_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.popped_value  (popped_value),
		.minimum_value (minimum_value),
		.minimum_valid (minimum_valid),
		.entry_count   (entry_count),
		.status        (status),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("min_tracking_stack_tb NOT OK");
			$finish;
		end
	end

	// result side: random stall bursts, plus long hold-offs on request
	initial begin : receiver
		int hold_left;
		int burst;
		forever begin
			@(posedge clk);
			if (hold_asked != hold_served) begin
				hold_served = hold_served + 1;
				out_stall <= 1'b1;
				hold_left = HOLD_CYCLES;
				while (hold_left > 0) begin
					@(posedge clk);
					hold_left = hold_left - 1;
				end
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 16);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// offer one input beat, maybe after a gap, and wait until it is taken
	task automatic send_op(input logic op, input logic signed [WORD_W-1:0] word);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= op;
		push_value <= word;
		do @(posedge clk); while (in_stall);
	endtask

	// stop offering and wait for every owed result beat
	task automatic wait_idle;
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin : stimulus
		int                       phase;
		int                       n;
		int                       run_left;
		int                       bias;
		logic                     op;
		logic signed [WORD_W-1:0] word;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, equal minimums and draining to empty at reset capacity
		send_op(MODE_POP, '0);
		send_op(MODE_PUSH, 32'sh7FFF_FFFF);
		send_op(MODE_PUSH, 32'sh8000_0000);
		send_op(MODE_PUSH, 32'sh8000_0000);
		send_op(MODE_PUSH, 32'sd5);
		repeat (4) send_op(MODE_POP, '0);

		// rescan must settle on the earliest of equal smallest words
		send_op(MODE_PUSH, 32'sd2);
		send_op(MODE_PUSH, 32'sd1);
		send_op(MODE_PUSH, 32'sd1);
		send_op(MODE_PUSH, 32'sd0);
		repeat (4) send_op(MODE_POP, '0);

		// capacity of one
		wait_idle();
		write_capacity(5'd1);
		send_op(MODE_PUSH, -32'sd1);
		send_op(MODE_PUSH, 32'sd7);
		send_op(MODE_POP, '0);

		// capacity of zero refuses every push
		wait_idle();
		write_capacity(5'd0);
		send_op(MODE_PUSH, 32'sd3);
		send_op(MODE_POP, '0);

		// capacity lowered below the fill level
		wait_idle();
		write_capacity(5'd16);
		send_op(MODE_PUSH, 32'sd4);
		send_op(MODE_PUSH, 32'sd3);
		send_op(MODE_PUSH, 32'sd2);
		wait_idle();
		write_capacity(5'd2);
		send_op(MODE_PUSH, 32'sd9);
		send_op(MODE_POP, '0);
		send_op(MODE_POP, '0);
		send_op(MODE_PUSH, 32'sd9);

		// random runs of pushes and pops under each capacity setting
		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			idle_on <= (phase % 3 != 2) && (phase != PHASES - 1);
			write_capacity(capacity_plan[phase]);
			run_left = 0;
			bias     = 0;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == 1 && n == 10) begin
					hold_asked <= hold_asked + 1;
				end
				if (run_left == 0) begin
					run_left = $urandom_range(1, 24);
					bias     = $urandom_range(0, 3);
				end
				run_left = run_left - 1;
				case (bias)
					0: op = MODE_PUSH;
					1: op = ($urandom_range(0, 3) != 0) ? MODE_PUSH : MODE_POP;
					2: op = ($urandom_range(0, 3) == 0) ? MODE_PUSH : MODE_POP;
					default: op = MODE_POP;
				endcase
				// small words give ties, plus both extremes and full range
				case ($urandom_range(0, 9))
					0, 1, 2: word = $urandom_range(0, 8) - 4;
					3: word = 32'sh7FFF_FFFF;
					4: word = 32'sh8000_0000;
					default: word = $urandom;
				endcase
				send_op(op, word);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("min_tracking_stack_tb OK");
		end else begin
			$display("min_tracking_stack_tb NOT OK");
		end
		$finish;
	end

endmodule
